// File: rtl/b32enc_pkg.sv
// ----------------------------------------------------------------------------
// b32enc_pkg
// Shared types, codes and character tables for the Base32 stream encoder.
// ----------------------------------------------------------------------------
package b32enc_pkg;

  localparam int CHAR_W    = 7;
  localparam int MAX_CHARS = 8;
  localparam int IDX_W     = 3;   // indexes MAX_CHARS entries
  localparam int CNT_W     = 4;   // holds 0..MAX_CHARS

  typedef logic [CHAR_W-1:0] char_t;

  // Register indexes
  localparam logic [7:0] REG_ALPHABET = 8'd0;
  localparam logic [7:0] REG_GROUPS   = 8'd1;

  // Alphabet codes
  localparam logic [1:0] ALPHA_CLASSIC = 2'd0;
  localparam logic [1:0] ALPHA_HEX     = 2'd1;
  localparam logic [1:0] ALPHA_ZBASE   = 2'd2;

  // Control characters
  localparam char_t CHAR_CR  = 7'd13;
  localparam char_t CHAR_LF  = 7'd10;
  localparam char_t CHAR_PAD = 7'd61;

  localparam logic [7:0] ZBASE_TABLE [32] = '{
    "y", "b", "n", "d", "r", "f", "g", "8", "e", "j", "k", "m", "c", "p", "q", "x",
    "o", "t", "1", "u", "w", "i", "s", "z", "a", "3", "4", "5", "h", "7", "6", "9"
  };

  // Symbol value to ASCII for the selected alphabet
  function automatic char_t sym_char(input logic [1:0] sel, input logic [4:0] s);
    logic [7:0] c;
    case (sel)
      ALPHA_HEX: begin
        c = (s < 5'd10) ? (8'd48 + {3'd0, s}) : (8'd55 + {3'd0, s});
      end
      ALPHA_ZBASE: begin
        c = ZBASE_TABLE[s];
      end
      default: begin
        // classic, also the unused code
        c = (s < 5'd26) ? (8'd65 + {3'd0, s}) : (8'd24 + {3'd0, s});
      end
    endcase
    return c[CHAR_W-1:0];
  endfunction

  // Number of '=' after the flush symbol, by phase left after the last byte
  function automatic logic [2:0] pad_len(input logic [2:0] phase);
    logic [2:0] n;
    case (phase)
      3'd1:    n = 3'd6;
      3'd2:    n = 3'd4;
      3'd3:    n = 3'd3;
      3'd4:    n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/base32_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// base32_stream_encoder_core
// Streaming Base32 encoder: one byte in, one to eight ASCII characters out.
// ----------------------------------------------------------------------------
// The first character of a byte passes through the character buffer and then
// the output register. The output carries one character per cycle while the
// buffer holds characters and out_ready is high; a new byte is taken when the
// last character of the previous byte moves out of the buffer.
// Reset (synchronous, rst high): phase, carry and group count cleared, buffer
// and output empty, alphabet classic, eight groups per line.
module base32_stream_encoder_core (
  input  logic                    clk,
  input  logic                    rst,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [7:0]              cfg_index,
  input  logic [7:0]              cfg_data,
  // input bytes
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_stream,
  // output characters
  output logic                    out_valid,
  input  logic                    out_ready,
  output b32enc_pkg::char_t       out_char,
  output logic                    last_of_run
);
  import b32enc_pkg::*;

  // configuration and encoder state
  logic [1:0] alphabet_select;
  logic [7:0] groups_per_line;
  logic [2:0] byte_phase;
  logic [4:0] carry_bits;
  logic [7:0] group_count;

  // character buffer
  char_t            buf_chars [MAX_CHARS];
  logic [IDX_W-1:0] buf_last_idx;
  logic [IDX_W-1:0] buf_idx;
  logic             buf_valid;

  // next-state values
  char_t            chars_next [MAX_CHARS];
  logic [CNT_W-1:0] count_next;
  logic [2:0]       byte_phase_next;
  logic [4:0]       carry_bits_next;
  logic [7:0]       group_count_next;

  logic accept, move, buf_drain;

  assign cfg_ready = 1'b1;
  assign move      = buf_valid && (!out_valid || out_ready);
  assign buf_drain = move && (buf_idx == buf_last_idx);
  assign in_ready  = !buf_valid || buf_drain;
  assign accept    = in_valid && in_ready;

  // encode one byte into its character list
  always_comb begin
    logic [4:0]       s0, s1;
    logic             two_syms, crlf;
    logic [7:0]       gc_inc;
    logic [CNT_W-1:0] flush_pos, pad_end;
    logic [2:0]       npad;
    logic [1:0]       sel;

    s0       = 5'd0;
    s1       = 5'd0;
    two_syms = 1'b0;
    crlf     = 1'b0;
    sel      = alphabet_select;
    gc_inc   = group_count;
    group_count_next = group_count;

    case (byte_phase)
      3'd1: begin
        s0 = carry_bits | {3'd0, data_byte[7:6]};
        s1 = data_byte[5:1];
        two_syms = 1'b1;
        carry_bits_next = {data_byte[0], 4'd0};
        byte_phase_next = 3'd2;
      end
      3'd2: begin
        s0 = carry_bits | {1'b0, data_byte[7:4]};
        carry_bits_next = {data_byte[3:0], 1'b0};
        byte_phase_next = 3'd3;
      end
      3'd3: begin
        s0 = carry_bits | {4'd0, data_byte[7]};
        s1 = data_byte[6:2];
        two_syms = 1'b1;
        carry_bits_next = {data_byte[1:0], 3'd0};
        byte_phase_next = 3'd4;
      end
      3'd4: begin
        s0 = carry_bits | {2'd0, data_byte[7:5]};
        s1 = data_byte[4:0];
        two_syms = 1'b1;
        carry_bits_next = 5'd0;
        byte_phase_next = 3'd0;
        gc_inc = (group_count != 8'd255) ? group_count + 8'd1 : group_count;
        group_count_next = gc_inc;
        if (gc_inc >= groups_per_line && !end_of_stream) begin
          crlf = 1'b1;
          group_count_next = 8'd0;
        end
      end
      default: begin
        s0 = data_byte[7:3];
        carry_bits_next = {data_byte[2:0], 2'd0};
        byte_phase_next = 3'd1;
      end
    endcase

    // symbols, then CR LF, then flush and padding at end of stream
    flush_pos = two_syms ? CNT_W'(2) : CNT_W'(1);
    npad = (sel == ALPHA_ZBASE) ? 3'd0 : pad_len(byte_phase_next);
    pad_end = flush_pos + CNT_W'(1) + {1'b0, npad};

    for (int k = 0; k < MAX_CHARS; k++) begin
      chars_next[k] = CHAR_PAD;
    end
    chars_next[0] = sym_char(sel, s0);
    chars_next[1] = sym_char(sel, s1);
    // line break follows both symbols of a completed group
    if (crlf) begin
      chars_next[2] = CHAR_CR;
      chars_next[3] = CHAR_LF;
    end
    count_next    = crlf ? CNT_W'(4) : flush_pos;

    if (end_of_stream) begin
      if (byte_phase_next != 3'd0) begin
        chars_next[flush_pos[IDX_W-1:0]] = sym_char(sel, carry_bits_next);
        count_next = pad_end;
      end
      byte_phase_next  = 3'd0;
      carry_bits_next  = 5'd0;
      group_count_next = 8'd0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_select <= ALPHA_CLASSIC;
      groups_per_line <= 8'd8;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ALPHABET) begin
        alphabet_select <= cfg_data[1:0];
      end else if (cfg_index == REG_GROUPS) begin
        groups_per_line <= cfg_data;
      end
    end
  end

  // encoder state, updated on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase  <= 3'd0;
      carry_bits  <= 5'd0;
      group_count <= 8'd0;
    end else if (accept) begin
      byte_phase  <= byte_phase_next;
      carry_bits  <= carry_bits_next;
      group_count <= group_count_next;
    end
  end

  // character buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_idx   <= '0;
    end else if (accept) begin
      buf_valid <= 1'b1;
      buf_idx   <= '0;
    end else if (buf_drain) begin
      buf_valid <= 1'b0;
    end else if (move) begin
      buf_idx <= buf_idx + IDX_W'(1);
    end
  end

  // character buffer payload
  always_ff @(posedge clk) begin
    if (accept) begin
      buf_chars    <= chars_next;
      buf_last_idx <= IDX_W'(count_next - CNT_W'(1));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_char    <= buf_chars[buf_idx];
      last_of_run <= (buf_idx == buf_last_idx);
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base32_stream_encoder_core: a predictor tracks the
// encoder state from each accepted byte and checks every character transfer.
// Directed streams hit each padding length and the line breaks, then random
// streams run under changing settings and varying idle on both sides.
// ----------------------------------------------------------------------------
module tb;
  import b32enc_pkg::*;

  typedef struct packed {
    char_t ch;
    logic  last;
  } enc_char_t;

  // Predicted encoder: register copies, stream state and queued characters
  class b32_char_predictor;
    logic [1:0] alpha;
    logic [7:0] line_groups;
    logic [2:0] phase;
    logic [4:0] carry;
    logic [7:0] groups;
    enc_char_t  pending_chars[$];
    int         errors;
    string      zalpha;

    function new();
      zalpha      = "ybndrfg8ejkmcpqxot1uwisza345h769";
      alpha       = ALPHA_CLASSIC;
      line_groups = 8'd8;
      phase       = 3'd0;
      carry       = 5'd0;
      groups      = 8'd0;
      errors      = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == REG_ALPHABET) begin
        alpha = val[1:0];
      end else if (idx == REG_GROUPS) begin
        line_groups = val;
      end
    endfunction

    function void push_char(char_t c);
      enc_char_t e;
      e.ch   = c;
      e.last = 1'b0;
      pending_chars.push_back(e);
    endfunction

    // 5-bit symbol to ASCII; the unused code falls back to classic
    function void push_sym(logic [4:0] s);
      logic [7:0] c;
      if (alpha == ALPHA_HEX) begin
        c = (s < 5'd10) ? 8'("0" + s) : 8'("A" + s - 10);
      end else if (alpha == ALPHA_ZBASE) begin
        c = zalpha.getc(s);
      end else begin
        c = (s < 5'd26) ? 8'("A" + s) : 8'("2" + s - 26);
      end
      push_char(c[CHAR_W-1:0]);
    endfunction

    // Accepted byte: queue every character it causes
    function void note_byte(logic [7:0] b, logic eos);
      enc_char_t tail;
      int        n;
      case (phase)
        3'd1: begin
          push_sym(carry | {3'd0, b[7:6]});
          push_sym(b[5:1]);
          carry = {b[0], 4'd0};
          phase = 3'd2;
        end
        3'd2: begin
          push_sym(carry | {1'b0, b[7:4]});
          carry = {b[3:0], 1'b0};
          phase = 3'd3;
        end
        3'd3: begin
          push_sym(carry | {4'd0, b[7]});
          push_sym(b[6:2]);
          carry = {b[1:0], 3'd0};
          phase = 3'd4;
        end
        3'd4: begin
          push_sym(carry | {2'd0, b[7:5]});
          push_sym(b[4:0]);
          carry = 5'd0;
          phase = 3'd0;
          if (groups < 8'd255) groups++;
          if (groups >= line_groups && !eos) begin
            push_char(CHAR_CR);
            push_char(CHAR_LF);
            groups = 8'd0;
          end
        end
        default: begin
          push_sym(b[7:3]);
          carry = {b[2:0], 2'd0};
          phase = 3'd1;
        end
      endcase
      // flush and pad on the final byte
      if (eos) begin
        if (phase != 3'd0) begin
          push_sym(carry);
          case (phase)
            3'd1:    n = 6;
            3'd2:    n = 4;
            3'd3:    n = 3;
            default: n = 1;
          endcase
          if (alpha == ALPHA_ZBASE) n = 0;
          repeat (n) push_char(CHAR_PAD);
        end
        phase  = 3'd0;
        carry  = 5'd0;
        groups = 8'd0;
      end
      tail = pending_chars.pop_back();
      tail.last = 1'b1;
      pending_chars.push_back(tail);
    endfunction

    function void check_char(char_t ch, logic last);
      enc_char_t e;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, ch, last);
        errors++;
        return;
      end
      e = pending_chars.pop_front();
      if (ch !== e.ch) begin
        $display("%0t: out_char expected %h actual %h", $time, e.ch, ch);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  // Settings for the first segment of each random phase; idle for the whole phase
  localparam logic [1:0] FIRST_ALPHA [3]  = '{2'd3, ALPHA_ZBASE, ALPHA_HEX};
  localparam logic [7:0] FIRST_GROUPS [3] = '{8'd0, 8'd255, 8'd1};
  localparam int SEND_IDLE [3] = '{33, 74, 0};
  localparam int RECV_IDLE [3] = '{74, 33, 0};

  logic       clk;
  logic       rst           = 1'b1;
  logic       cfg_valid     = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index     = 8'd0;
  logic [7:0] cfg_data      = 8'd0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte     = 8'd0;
  logic       end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  char_t      out_char;
  logic       last_of_run;

  b32_char_predictor char_pred = new();
  int send_idle_pct = SEND_IDLE[0];
  int recv_idle_pct = RECV_IDLE[0];
  int stream_left   = 0;

  base32_stream_encoder_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .last_of_run   (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check each character transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) char_pred.check_char(out_char, last_of_run);
  end

  // One byte transfer, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    char_pred.note_byte(b, eos);
  endtask

  // Hold off input until every queued character has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (char_pred.pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    char_pred.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random byte from the current stream; streams may span segments
  task automatic send_random_byte();
    if (stream_left == 0) begin
      stream_left = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 12)
                                                 : $urandom_range(13, 45);
    end
    stream_left--;
    send_byte(8'($urandom_range(0, 255)), stream_left == 0);
  endtask

  // Limit
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int ph;
    int seg;
    int pick;
    logic [7:0] groups_val;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: one stream per padding length, classic, eight groups per line
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hC3, 1'b1);
    // final byte completes a group: no flush, no padding
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'hFF, 1'b1);
    // hex, a break after every group
    wait_idle();
    write_reg(REG_ALPHABET, {6'd0, ALPHA_HEX});
    write_reg(REG_GROUPS, 8'd1);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'h00, 1'b0);
    // z-base-32 through upper data bits, zero groups per line, no padding
    wait_idle();
    write_reg(REG_ALPHABET, {6'h3F, ALPHA_ZBASE});
    write_reg(REG_GROUPS, 8'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);

    // Random phases: settings change between segments, often mid-stream
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      recv_idle_pct = RECV_IDLE[ph];
      for (seg = 0; seg < 5; seg++) begin
        wait_idle();
        if (seg == 0) begin
          write_reg(REG_ALPHABET, {6'($urandom_range(0, 63)), FIRST_ALPHA[ph]});
          write_reg(REG_GROUPS, FIRST_GROUPS[ph]);
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 6)       groups_val = 8'($urandom_range(0, 3));
          else if (pick == 6) groups_val = 8'd255;
          else if (pick == 7) groups_val = 8'd8;
          else                groups_val = 8'($urandom_range(0, 255));
          write_reg(REG_ALPHABET, 8'($urandom_range(0, 255)));
          write_reg(REG_GROUPS, groups_val);
          // writes to unused indexes must be ignored
          if ($urandom_range(0, 1) != 0) begin
            write_reg(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
          end
        end
        repeat (6) send_random_byte();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (char_pred.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
